### hw/rtl/lroq_pkg.sv
// Shared types and constants of the lease-ranked offer queue.
// Used by the controller, the datapath, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package lroq_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;

	localparam int LEASE_W  = 32;
	localparam int IP_W     = 32;
	localparam int HANDLE_W = 16;
	localparam int KIND_W   = 3;

	localparam int S_TDATA_W = LEASE_W + IP_W + HANDLE_W + IP_W;
	localparam int M_TDATA_W = HANDLE_W + IP_W;

	typedef enum logic [KIND_W-1:0] {
		KIND_MATCH   = 3'd0,
		KIND_LONGEST = 3'd1,
		KIND_DISCARD = 3'd2,
		KIND_EMPTY   = 3'd3,
		KIND_REJECT  = 3'd4
	} kind_t;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_SELECT = 1'b1
	} op_t;

	typedef struct packed {
		logic [LEASE_W-1:0]  lease;
		logic [IP_W-1:0]     ip;
		logic [HANDLE_W-1:0] handle;
	} entry_t;

	typedef enum logic [2:0] {
		IDX_HOLD,
		IDX_CLR,
		IDX_LAST,
		IDX_INC,
		IDX_DEC
	} idx_op_t;

	typedef enum logic [1:0] {
		WR_NONE,
		WR_SHIFT,
		WR_NEW
	} wr_op_t;

	typedef enum logic [1:0] {
		PICK_HOLD,
		PICK_IDX,
		PICK_HEAD
	} pick_op_t;

	typedef enum logic [2:0] {
		OUT_NONE,
		OUT_REJECT,
		OUT_EMPTY,
		OUT_PICK,
		OUT_DISCARD
	} out_sel_t;

	typedef struct packed {
		logic     load_in;
		idx_op_t  idx_op;
		logic     mem_rd;
		logic     rd_pick;
		wr_op_t   wr_op;
		pick_op_t pick_op;
		logic     k_clr;
		logic     k_inc;
		logic     count_clr;
		out_sel_t out_sel;
	} cmd_t;

	typedef struct packed {
		logic op;
		logic cnt_zero;
		logic full;
		logic idx_is_last;
		logic idx_zero;
		logic idx_is_pick;
		logic idx_at_end;
		logic lease_gt;
		logic addr_eq;
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

### hw/rtl/lease_ranked_offer_queue.sv
// Top level of the lease-ranked offer queue: stream ports, controller and datapath.
// Depends on lroq_pkg, lroq_ctrl and lroq_dp.
`timescale 1ns / 1ps
`default_nettype none

// Holds up to QUEUE_DEPTH offers sorted by falling lease time in a single-port
// entry memory with registered read data. One request is taken at a time;
// s_tready is high only while the block is idle. An insert reads the held
// entries from the tail toward the head: each one whose lease does not exceed the
// new one is moved up one place, and the walk stops after the first entry with
// a longer lease or at the head. A select scans entries from the head until the
// first address match (or all n entries), then gives its n results, and any
// result can stall on m_tready; every per-entry step waits on the memory read.
// Results leave through a register, so the next request may be taken while the
// last result waits.
module lease_ranked_offer_queue #(
	parameter int QUEUE_DEPTH = lroq_pkg::QUEUE_DEPTH_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               s_tvalid,
	output logic                              s_tready,
	// lease_time[31:0], offer_addr[63:32], packet_handle[79:64], requested_ip[111:80]
	input  wire [lroq_pkg::S_TDATA_W-1:0]     s_tdata,
	// operation[0]
	input  wire                               s_tuser,
	output logic                              m_tvalid,
	input  wire                               m_tready,
	// packet_handle_res[15:0], entry_ip[47:16]
	output logic [lroq_pkg::M_TDATA_W-1:0]    m_tdata,
	// kind[2:0]
	output logic [lroq_pkg::KIND_W-1:0]       m_tuser,
	output logic                              m_tlast
);

	lroq_pkg::cmd_t                cmd;
	lroq_pkg::status_t             status;
	lroq_pkg::entry_t              in_entry;
	logic [lroq_pkg::IP_W-1:0]     in_req;
	logic [lroq_pkg::HANDLE_W-1:0] out_handle;
	logic [lroq_pkg::IP_W-1:0]     out_ip;

	assign in_entry.lease  = s_tdata[31:0];
	assign in_entry.ip     = s_tdata[63:32];
	assign in_entry.handle = s_tdata[79:64];
	assign in_req          = s_tdata[111:80];

	lroq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	lroq_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_op      (s_tuser),
		.in_entry   (in_entry),
		.in_req     (in_req),
		.cmd        (cmd),
		.status     (status),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.out_kind   (m_tuser),
		.out_handle (out_handle),
		.out_ip     (out_ip),
		.out_last   (m_tlast)
	);

	assign m_tdata = {out_ip, out_handle};

endmodule

`default_nettype wire

### hw/rtl/lroq_dp.sv
// Datapath of the lease-ranked offer queue: entry memory, index and count
// registers, comparators and the result register. Depends on lroq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lroq_dp #(
	parameter int QUEUE_DEPTH = lroq_pkg::QUEUE_DEPTH_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                in_op,
	input  wire lroq_pkg::entry_t              in_entry,
	input  wire [lroq_pkg::IP_W-1:0]           in_req,
	input  wire lroq_pkg::cmd_t                cmd,
	output lroq_pkg::status_t                  status,
	input  wire                                out_ready,
	output logic                               out_valid,
	output logic [lroq_pkg::KIND_W-1:0]        out_kind,
	output logic [lroq_pkg::HANDLE_W-1:0]      out_handle,
	output logic [lroq_pkg::IP_W-1:0]          out_ip,
	output logic                               out_last
);

	localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic                      op_q;
	lroq_pkg::entry_t          new_q;
	logic [lroq_pkg::IP_W-1:0] req_q;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] k_q;
	logic [IDX_W-1:0] pick_q;
	logic             found_q;

	lroq_pkg::entry_t mem [QUEUE_DEPTH];
	lroq_pkg::entry_t rdata_q;

	logic [IDX_W-1:0] rd_addr;
	logic [IDX_W-1:0] idx_addr;
	logic [CNT_W-1:0] count_m1;

	logic                          out_valid_q;
	logic [lroq_pkg::KIND_W-1:0]   kind_q;
	logic [lroq_pkg::HANDLE_W-1:0] handle_q;
	logic [lroq_pkg::IP_W-1:0]     ip_q;
	logic                          last_q;

	assign idx_addr = idx_q[IDX_W-1:0];
	assign rd_addr  = cmd.rd_pick ? pick_q : idx_addr;
	assign count_m1 = count_q - CNT_W'(1);

	// capture request
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q  <= in_op;
			new_q <= in_entry;
			req_q <= in_req;
		end
	end

	// entry memory
	always_ff @(posedge clk) begin
		case (cmd.wr_op)
			lroq_pkg::WR_SHIFT: mem[idx_addr + IDX_W'(1)] <= rdata_q;
			lroq_pkg::WR_NEW:   mem[idx_addr] <= new_q;
			default: ;
		endcase
		if (cmd.mem_rd)
			rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
			k_q     <= '0;
			pick_q  <= '0;
			found_q <= 1'b0;
		end else begin
			if (cmd.count_clr)
				count_q <= '0;
			else if (cmd.wr_op == lroq_pkg::WR_NEW)
				count_q <= count_q + CNT_W'(1);

			case (cmd.idx_op)
				lroq_pkg::IDX_CLR:  idx_q <= '0;
				lroq_pkg::IDX_LAST: idx_q <= count_m1;
				lroq_pkg::IDX_INC:  idx_q <= idx_q + CNT_W'(1);
				lroq_pkg::IDX_DEC:  idx_q <= idx_q - CNT_W'(1);
				default: ;
			endcase

			if (cmd.k_clr)
				k_q <= CNT_W'(1);
			else if (cmd.k_inc)
				k_q <= k_q + CNT_W'(1);

			case (cmd.pick_op)
				lroq_pkg::PICK_IDX: begin
					pick_q  <= idx_addr;
					found_q <= 1'b1;
				end
				lroq_pkg::PICK_HEAD: begin
					pick_q  <= '0;
					found_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	assign status.op          = op_q;
	assign status.cnt_zero    = (count_q == '0);
	assign status.full        = (count_q == CNT_W'(QUEUE_DEPTH));
	assign status.idx_is_last = (idx_q == count_m1);
	assign status.idx_zero    = (idx_q == '0);
	assign status.idx_is_pick = (idx_q == CNT_W'(pick_q));
	assign status.idx_at_end  = (idx_q == count_q);
	assign status.lease_gt    = (rdata_q.lease > new_q.lease);
	assign status.addr_eq     = (rdata_q.ip == req_q);
	assign status.out_free    = !out_valid_q || out_ready;

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_sel != lroq_pkg::OUT_NONE)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		case (cmd.out_sel)
			lroq_pkg::OUT_REJECT: begin
				kind_q   <= lroq_pkg::KIND_REJECT;
				handle_q <= new_q.handle;
				ip_q     <= new_q.ip;
				last_q   <= 1'b1;
			end
			lroq_pkg::OUT_EMPTY: begin
				kind_q   <= lroq_pkg::KIND_EMPTY;
				handle_q <= '0;
				ip_q     <= '0;
				last_q   <= 1'b1;
			end
			lroq_pkg::OUT_PICK: begin
				kind_q   <= found_q ? lroq_pkg::KIND_MATCH : lroq_pkg::KIND_LONGEST;
				handle_q <= rdata_q.handle;
				ip_q     <= rdata_q.ip;
				last_q   <= (count_q == CNT_W'(1));
			end
			lroq_pkg::OUT_DISCARD: begin
				kind_q   <= lroq_pkg::KIND_DISCARD;
				handle_q <= rdata_q.handle;
				ip_q     <= rdata_q.ip;
				last_q   <= (k_q + CNT_W'(1) == count_q);
			end
			default: ;
		endcase
	end

	assign out_valid  = out_valid_q;
	assign out_kind   = kind_q;
	assign out_handle = handle_q;
	assign out_ip     = ip_q;
	assign out_last   = last_q;

endmodule

`default_nettype wire

### hw/rtl/lroq_ctrl.sv
// Controller state machine of the lease-ranked offer queue.
// Drives the datapath command struct from its status struct; depends on lroq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lroq_ctrl (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     in_valid,
	output logic                    in_ready,
	input  wire lroq_pkg::status_t  status,
	output lroq_pkg::cmd_t          cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_INS_RD,
		ST_INS_WR,
		ST_INS_PUT,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_PICK_RD,
		ST_PICK_OUT,
		ST_DISC_CHK,
		ST_DISC_OUT,
		ST_REPLY
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		cmd.idx_op    = lroq_pkg::IDX_HOLD;
		cmd.wr_op     = lroq_pkg::WR_NONE;
		cmd.pick_op   = lroq_pkg::PICK_HOLD;
		cmd.out_sel   = lroq_pkg::OUT_NONE;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				if (status.op == lroq_pkg::OP_INSERT) begin
					if (status.full) begin
						state_d = ST_REPLY;
					end else if (status.cnt_zero) begin
						cmd.idx_op = lroq_pkg::IDX_CLR;
						state_d    = ST_INS_PUT;
					end else begin
						cmd.idx_op = lroq_pkg::IDX_LAST;
						state_d    = ST_INS_RD;
					end
				end else if (status.cnt_zero) begin
					state_d = ST_REPLY;
				end else begin
					cmd.idx_op = lroq_pkg::IDX_CLR;
					state_d    = ST_SCAN_RD;
				end
			end
			ST_INS_RD: begin
				cmd.mem_rd = 1'b1;
				state_d    = ST_INS_WR;
			end
			ST_INS_WR: begin
				if (status.lease_gt) begin
					cmd.idx_op = lroq_pkg::IDX_INC;
					state_d    = ST_INS_PUT;
				end else begin
					cmd.wr_op = lroq_pkg::WR_SHIFT;
					if (status.idx_zero) begin
						state_d = ST_INS_PUT;
					end else begin
						cmd.idx_op = lroq_pkg::IDX_DEC;
						state_d    = ST_INS_RD;
					end
				end
			end
			ST_INS_PUT: begin
				cmd.wr_op = lroq_pkg::WR_NEW;
				state_d   = ST_IDLE;
			end
			ST_SCAN_RD: begin
				cmd.mem_rd = 1'b1;
				state_d    = ST_SCAN_CHK;
			end
			ST_SCAN_CHK: begin
				if (status.addr_eq) begin
					cmd.pick_op = lroq_pkg::PICK_IDX;
					state_d     = ST_PICK_RD;
				end else if (status.idx_is_last) begin
					cmd.pick_op = lroq_pkg::PICK_HEAD;
					state_d     = ST_PICK_RD;
				end else begin
					cmd.idx_op = lroq_pkg::IDX_INC;
					state_d    = ST_SCAN_RD;
				end
			end
			ST_PICK_RD: begin
				cmd.mem_rd  = 1'b1;
				cmd.rd_pick = 1'b1;
				state_d     = ST_PICK_OUT;
			end
			ST_PICK_OUT: begin
				if (status.out_free) begin
					cmd.out_sel = lroq_pkg::OUT_PICK;
					cmd.idx_op  = lroq_pkg::IDX_CLR;
					cmd.k_clr   = 1'b1;
					state_d     = ST_DISC_CHK;
				end
			end
			ST_DISC_CHK: begin
				if (status.idx_at_end) begin
					cmd.count_clr = 1'b1;
					state_d       = ST_IDLE;
				end else if (status.idx_is_pick) begin
					cmd.idx_op = lroq_pkg::IDX_INC;
				end else begin
					cmd.mem_rd = 1'b1;
					state_d    = ST_DISC_OUT;
				end
			end
			ST_DISC_OUT: begin
				if (status.out_free) begin
					cmd.out_sel = lroq_pkg::OUT_DISCARD;
					cmd.k_inc   = 1'b1;
					cmd.idx_op  = lroq_pkg::IDX_INC;
					state_d     = ST_DISC_CHK;
				end
			end
			ST_REPLY: begin
				if (status.out_free) begin
					cmd.out_sel = (status.op == lroq_pkg::OP_SELECT) ?
						lroq_pkg::OUT_EMPTY : lroq_pkg::OUT_REJECT;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

`default_nettype wire

### hw/rtl/lroq_checker.sv
// Port-level checker of the lease-ranked offer queue and its bind to the top level.
// Depends on lroq_pkg and lease_ranked_offer_queue.
`timescale 1ns / 1ps
`default_nettype none

module lroq_checker (
	input wire                             clk,
	input wire                             arst_n,
	input wire                             s_tready,
	input wire                             m_tvalid,
	input wire                             m_tready,
	input wire [lroq_pkg::M_TDATA_W-1:0]   m_tdata,
	input wire [lroq_pkg::KIND_W-1:0]      m_tuser,
	input wire                             m_tlast
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result dropped or changed while stalled");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == lroq_pkg::KIND_EMPTY || m_tuser == lroq_pkg::KIND_REJECT)
		|-> m_tlast)
		else $error("empty or reject result without last");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == lroq_pkg::KIND_EMPTY |-> m_tdata == '0)
		else $error("empty result carries data");

	a_busy_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> !s_tready)
		else $error("request taken before run of results ended");

endmodule

bind lease_ranked_offer_queue lroq_checker u_lroq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

`default_nettype wire
